FILE: src/fgcb_pkg.sv
// Shared types and constants for the frame grid color binning block.
package fgcb_pkg;

   localparam int CFG_DIM_W   = 14;
   localparam int CFG_SKIP_W  = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 14;
   localparam int PIX_W       = 8;
   localparam int TOTAL_W     = 32;
   localparam int COUNT_W     = 20;
   localparam int BIN_NUM_W   = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_SKIP  = 2'd2;

   localparam logic [CFG_DIM_W-1:0]  FRAME_WIDTH_RESET  = 14'd1920;
   localparam logic [CFG_DIM_W-1:0]  FRAME_HEIGHT_RESET = 14'd1080;
   localparam logic [CFG_SKIP_W-1:0] SAMPLE_SKIP_RESET  = 8'd32;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [TOTAL_W-1:0] red;
      logic [TOTAL_W-1:0] green;
      logic [TOTAL_W-1:0] blue;
      logic [COUNT_W-1:0] count;
   } bin_word_type;

   typedef struct packed {
      logic [BIN_NUM_W-1:0] bin_number;
      logic [TOTAL_W-1:0]   red;
      logic [TOTAL_W-1:0]   green;
      logic [TOTAL_W-1:0]   blue;
      logic [COUNT_W-1:0]   count;
   } rsp_beat_type;

   typedef struct packed {
      logic valid;
      logic pixel;
      logic frame_start;
      logic sample;
      logic respond;
   } stage_ctrl_type;

endpackage

FILE: src/fgcb_ram.sv
// Generic single write port, single read port RAM with registered read.
module fgcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_address,
   input  logic [WIDTH-1:0]  write_data,
   input  logic [ADDR_W-1:0] read_address,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

FILE: src/fgcb_position.sv
// Raster position, sample phase and grid bin tracking for pixel beats.
module fgcb_position
   import fgcb_pkg::*;
#(
   parameter int GRID_COLUMNS = 16,
   parameter int GRID_ROWS = 9,
   parameter int MAX_FRAME_DIM = 8192,
   parameter int BIN_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  frame_start,
   input  logic [CFG_DIM_W-1:0]  cfg_width,
   input  logic [CFG_DIM_W-1:0]  cfg_height,
   input  logic [CFG_SKIP_W-1:0] cfg_skip,
   output logic [BIN_W-1:0]      bin_index,
   output logic                  sample
);

   localparam int COL_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
   localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int DIM_W = $clog2(MAX_FRAME_DIM + 1);
   localparam int POS_W = $clog2(MAX_FRAME_DIM);
   localparam int CMP_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
   localparam int REM_W = DIM_W + 1;

   localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_FRAME_DIM);
   localparam logic [CMP_W-1:0] COLS_CMP = CMP_W'(GRID_COLUMNS);
   localparam logic [CMP_W-1:0] ROWS_CMP = CMP_W'(GRID_ROWS);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
   localparam logic [REM_W-1:0] COL_STEP = REM_W'(GRID_COLUMNS);
   localparam logic [REM_W-1:0] ROW_STEP = REM_W'(GRID_ROWS);
   localparam logic [BIN_W-1:0] COLS_BIN = BIN_W'(GRID_COLUMNS);

   logic [POS_W-1:0]      col_pos_ff, col_pos_in, row_pos_ff, row_pos_in;
   logic [COL_W-1:0]      col_bin_ff, col_bin_in;
   logic [ROW_W-1:0]      row_bin_ff, row_bin_in;
   logic [POS_W-1:0]      col_rem_ff, col_rem_in, row_rem_ff, row_rem_in;
   logic [CFG_SKIP_W-1:0] col_phase_ff, col_phase_in, row_phase_ff, row_phase_in;

   logic [POS_W-1:0]      col_pos, row_pos, col_rem, row_rem;
   logic [COL_W-1:0]      col_bin, col_bin_cl;
   logic [ROW_W-1:0]      row_bin, row_bin_cl;
   logic [CFG_SKIP_W-1:0] col_phase, row_phase;
   logic [CMP_W-1:0]      width_ext, height_ext, width_cl, height_cl;
   logic [DIM_W-1:0]      width_dim, height_dim, col_pos_inc, row_pos_inc;
   logic [REM_W-1:0]      col_rem_sum, row_rem_sum;

   always_comb begin
      // frame start puts the beat at the origin before it is sampled
      col_pos = frame_start ? '0 : col_pos_ff;
      row_pos = frame_start ? '0 : row_pos_ff;
      col_bin = frame_start ? '0 : col_bin_ff;
      row_bin = frame_start ? '0 : row_bin_ff;
      col_rem = frame_start ? '0 : col_rem_ff;
      row_rem = frame_start ? '0 : row_rem_ff;
      col_phase = (frame_start || col_phase_ff > cfg_skip) ? '0 : col_phase_ff;
      row_phase = (frame_start || row_phase_ff > cfg_skip) ? '0 : row_phase_ff;

      sample     = (col_phase == '0) && (row_phase == '0);
      col_bin_cl = (col_bin > COL_LAST) ? COL_LAST : col_bin;
      row_bin_cl = (row_bin > ROW_LAST) ? ROW_LAST : row_bin;
      bin_index  = BIN_W'(row_bin_cl) * COLS_BIN + BIN_W'(col_bin_cl);

      width_ext  = CMP_W'(cfg_width);
      height_ext = CMP_W'(cfg_height);
      if (width_ext < COLS_CMP) begin
         width_cl = COLS_CMP;
      end else if (width_ext > MAX_CMP) begin
         width_cl = MAX_CMP;
      end else begin
         width_cl = width_ext;
      end
      if (height_ext < ROWS_CMP) begin
         height_cl = ROWS_CMP;
      end else if (height_ext > MAX_CMP) begin
         height_cl = MAX_CMP;
      end else begin
         height_cl = height_ext;
      end
      width_dim  = width_cl[DIM_W-1:0];
      height_dim = height_cl[DIM_W-1:0];

      col_pos_inc = DIM_W'(col_pos) + DIM_W'(1);
      row_pos_inc = DIM_W'(row_pos) + DIM_W'(1);
      col_rem_sum = REM_W'(col_rem) + COL_STEP;
      row_rem_sum = REM_W'(row_rem) + ROW_STEP;

      col_pos_in   = col_pos;
      col_bin_in   = col_bin;
      col_rem_in   = col_rem;
      col_phase_in = col_phase;
      row_pos_in   = row_pos;
      row_bin_in   = row_bin;
      row_rem_in   = row_rem;
      row_phase_in = row_phase;

      if (col_pos_inc < width_dim) begin
         col_pos_in = col_pos_inc[POS_W-1:0];
         if (col_rem_sum >= REM_W'(width_dim)) begin
            col_rem_in = POS_W'(col_rem_sum - REM_W'(width_dim));
            if (col_bin < COL_LAST) begin
               col_bin_in = col_bin + COL_W'(1);
            end
         end else begin
            col_rem_in = POS_W'(col_rem_sum);
         end
         col_phase_in = (col_phase >= cfg_skip) ? '0 : col_phase + CFG_SKIP_W'(1);
      end else begin
         // wrap the column, then step or wrap the row
         col_pos_in   = '0;
         col_bin_in   = '0;
         col_rem_in   = '0;
         col_phase_in = '0;
         if (row_pos_inc < height_dim) begin
            row_pos_in = row_pos_inc[POS_W-1:0];
            if (row_rem_sum >= REM_W'(height_dim)) begin
               row_rem_in = POS_W'(row_rem_sum - REM_W'(height_dim));
               if (row_bin < ROW_LAST) begin
                  row_bin_in = row_bin + ROW_W'(1);
               end
            end else begin
               row_rem_in = POS_W'(row_rem_sum);
            end
            row_phase_in = (row_phase >= cfg_skip) ? '0 : row_phase + CFG_SKIP_W'(1);
         end else begin
            row_pos_in   = '0;
            row_bin_in   = '0;
            row_rem_in   = '0;
            row_phase_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         col_bin_ff   <= '0;
         row_bin_ff   <= '0;
         col_rem_ff   <= '0;
         row_rem_ff   <= '0;
         col_phase_ff <= '0;
         row_phase_ff <= '0;
      end else if (advance) begin
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         col_bin_ff   <= col_bin_in;
         row_bin_ff   <= row_bin_in;
         col_rem_ff   <= col_rem_in;
         row_rem_ff   <= row_rem_in;
         col_phase_ff <= col_phase_in;
         row_phase_ff <= row_phase_in;
      end
   end

endmodule

FILE: src/fgcb_bins.sv
// Bin storage with read-modify-write accumulate, valid bits and write forwarding.
module fgcb_bins
   import fgcb_pkg::*;
#(
   parameter int NUM_BINS = 144,
   parameter int BIN_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [BIN_W-1:0]     read_address,
   input  stage_ctrl_type       s1_ctrl,
   input  logic [BIN_W-1:0]     s1_index,
   input  logic [BIN_NUM_W-1:0] s1_bin_number,
   input  logic [PIX_W-1:0]     s1_red,
   input  logic [PIX_W-1:0]     s1_green,
   input  logic [PIX_W-1:0]     s1_blue,
   output logic                 rsp_push,
   output rsp_beat_type         rsp_beat
);

   localparam int WORD_W = $bits(bin_word_type);

   logic [NUM_BINS-1:0] valid_ff, valid_in;
   logic                fwd_valid_ff;
   logic [BIN_W-1:0]    fwd_addr_ff;
   bin_word_type        fwd_data_ff;

   logic [WORD_W-1:0]   ram_rdata;
   bin_word_type        stored, current, updated;
   logic                live, write_en;
   logic [TOTAL_W:0]    red_sum, green_sum, blue_sum;
   logic [COUNT_W:0]    count_sum;

   fgcb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_BINS),
      .ADDR_W(BIN_W)
   ) u_ram (
      .clock        (clock),
      .write_enable (write_en),
      .write_address(s1_index),
      .write_data   (updated),
      .read_address (read_address),
      .read_data    (ram_rdata)
   );

   always_comb begin
      // the previous beat's write lands on the same edge as this beat's read
      stored   = (fwd_valid_ff && fwd_addr_ff == s1_index) ? fwd_data_ff
                                                           : bin_word_type'(ram_rdata);
      live     = valid_ff[s1_index] && !(s1_ctrl.pixel && s1_ctrl.frame_start);
      current  = live ? stored : '0;
      write_en = s1_ctrl.valid && s1_ctrl.pixel && s1_ctrl.sample;

      red_sum   = {1'b0, current.red} + (TOTAL_W + 1)'(s1_red);
      green_sum = {1'b0, current.green} + (TOTAL_W + 1)'(s1_green);
      blue_sum  = {1'b0, current.blue} + (TOTAL_W + 1)'(s1_blue);
      count_sum = {1'b0, current.count} + (COUNT_W + 1)'(1);

      updated.red   = red_sum[TOTAL_W] ? TOTAL_MAX : red_sum[TOTAL_W-1:0];
      updated.green = green_sum[TOTAL_W] ? TOTAL_MAX : green_sum[TOTAL_W-1:0];
      updated.blue  = blue_sum[TOTAL_W] ? TOTAL_MAX : blue_sum[TOTAL_W-1:0];
      updated.count = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];

      // drop every bin at frame start, then mark the one just written
      valid_in = valid_ff;
      if (s1_ctrl.valid && s1_ctrl.pixel && s1_ctrl.frame_start) begin
         valid_in = '0;
      end
      if (write_en) begin
         valid_in[s1_index] = 1'b1;
      end

      rsp_push            = s1_ctrl.valid && s1_ctrl.respond;
      rsp_beat.bin_number = s1_bin_number;
      rsp_beat.red        = current.red;
      rsp_beat.green      = current.green;
      rsp_beat.blue       = current.blue;
      rsp_beat.count      = current.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         fwd_valid_ff <= write_en;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         fwd_addr_ff <= s1_index;
         fwd_data_ff <= updated;
      end
   end

endmodule

FILE: src/fgcb_rsp_buffer.sv
// Two-entry response buffer that decouples the pipeline from rsp_ready.
module fgcb_rsp_buffer
   import fgcb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_beat_type push_beat,
   input  logic         pop_ready,
   output logic         out_valid,
   output rsp_beat_type out_beat,
   output logic [1:0]   level
);

   logic [1:0]   count_ff, count_in;
   rsp_beat_type head_ff, head_in, tail_ff, tail_in;
   logic         pop;

   always_comb begin
      pop      = (count_ff != 2'd0) && pop_ready;
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               head_in = push_beat;
            end else begin
               tail_in = push_beat;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            head_in  = tail_ff;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = push_beat;
            end else begin
               head_in = tail_ff;
               tail_in = push_beat;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_beat  = head_ff;
   assign level     = count_ff;

endmodule

FILE: src/frame_grid_color_binning_core.sv
// Top level of the frame grid color binning block.
//
// Request channel (req_*): one beat per pixel or per bin read. A pixel beat
// carries BGR components and a frame_start flag; it is binned into a
// GRID_COLUMNS x GRID_ROWS grid when its column and row are multiples of
// sample_skip+1. A read beat names a bin and returns its red, green and blue
// totals and sample count on the response channel (rsp_*); a read of a bin
// past the grid returns nothing. Pixel beats return nothing.
// Configuration (csr_*): frame width, height and sample skip, written while
// the block is idle.
// Throughput: one beat per cycle while req_ready is high, pixels and reads
// mixed. The bin store is one RAM with one read and one write port; the read
// at acceptance and the write in the cycle after, with a one-deep forward,
// carry the read-modify-write of each pixel at that rate.
// A read result is registered in stage 1 and then in the response buffer.
// The two-entry buffer takes the result; req_ready falls only while
// the buffered results and any read in flight would fill it and rsp_ready is low.
// Reset: registers return to 1920 x 1080 with skip 32, the position goes to
// the origin and every bin reads as zero. No clearing pass is needed.
module frame_grid_color_binning_core
   import fgcb_pkg::*;
#(
   parameter int GRID_COLUMNS = 16,
   parameter int GRID_ROWS = 9,
   parameter int MAX_FRAME_DIM = 8192
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  logic                   req_frame_start,
   input  logic [PIX_W-1:0]       req_blue,
   input  logic [PIX_W-1:0]       req_green,
   input  logic [PIX_W-1:0]       req_red,
   input  logic [BIN_NUM_W-1:0]   req_read_index,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BIN_NUM_W-1:0]   rsp_bin_number,
   output logic [TOTAL_W-1:0]     rsp_red_total,
   output logic [TOTAL_W-1:0]     rsp_green_total,
   output logic [TOTAL_W-1:0]     rsp_blue_total,
   output logic [COUNT_W-1:0]     rsp_sample_total
);

   localparam int NUM_BINS  = GRID_COLUMNS * GRID_ROWS;
   localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int IDX_CMP_W = ((BIN_W > BIN_NUM_W) ? BIN_W : BIN_NUM_W) + 1;
   localparam logic [IDX_CMP_W-1:0] NUM_BINS_CMP = IDX_CMP_W'(NUM_BINS);

   logic [CFG_DIM_W-1:0]  width_ff, height_ff;
   logic [CFG_SKIP_W-1:0] skip_ff;

   stage_ctrl_type        s1_ctrl_ff, s1_ctrl_in;
   logic [BIN_W-1:0]      s1_index_ff, s1_index_in;
   logic [BIN_NUM_W-1:0]  s1_bin_number_ff;
   logic [PIX_W-1:0]      s1_red_ff, s1_green_ff, s1_blue_ff;

   logic                  accept, is_pixel, pos_sample, rsp_push, pop;
   logic [BIN_W-1:0]      pos_index;
   logic [IDX_CMP_W-1:0]  read_index_ext;
   logic [1:0]            buf_level;
   logic [2:0]            pending;
   rsp_beat_type          push_beat, out_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
         skip_ff   <= SAMPLE_SKIP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_write_data;
            CSR_FRAME_HEIGHT: height_ff <= csr_write_data;
            CSR_SAMPLE_SKIP:  skip_ff   <= csr_write_data[CFG_SKIP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // hold off a new beat only when the read in flight could overrun the buffer
   assign pop       = rsp_valid && rsp_ready;
   assign pending   = 3'(buf_level) + 3'(s1_ctrl_ff.valid && s1_ctrl_ff.respond);
   assign req_ready = (pending <= 3'd1) || ((pending == 3'd2) && pop);
   assign accept    = req_valid && req_ready;
   assign is_pixel  = (req_operation == OP_PIXEL);

   fgcb_position #(
      .GRID_COLUMNS (GRID_COLUMNS),
      .GRID_ROWS    (GRID_ROWS),
      .MAX_FRAME_DIM(MAX_FRAME_DIM),
      .BIN_W        (BIN_W)
   ) u_position (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept && is_pixel),
      .frame_start(req_frame_start),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .cfg_skip   (skip_ff),
      .bin_index  (pos_index),
      .sample     (pos_sample)
   );

   always_comb begin
      read_index_ext         = IDX_CMP_W'(req_read_index);
      s1_ctrl_in.valid       = accept;
      s1_ctrl_in.pixel       = is_pixel;
      s1_ctrl_in.frame_start = is_pixel && req_frame_start;
      s1_ctrl_in.sample      = is_pixel && pos_sample;
      s1_ctrl_in.respond     = (req_operation == OP_READ) && (read_index_ext < NUM_BINS_CMP);
      s1_index_in            = is_pixel ? pos_index : read_index_ext[BIN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_index_ff      <= s1_index_in;
      s1_bin_number_ff <= req_read_index;
      s1_red_ff        <= req_red;
      s1_green_ff      <= req_green;
      s1_blue_ff       <= req_blue;
   end

   fgcb_bins #(
      .NUM_BINS(NUM_BINS),
      .BIN_W   (BIN_W)
   ) u_bins (
      .clock        (clock),
      .reset        (reset),
      .read_address (s1_index_in),
      .s1_ctrl      (s1_ctrl_ff),
      .s1_index     (s1_index_ff),
      .s1_bin_number(s1_bin_number_ff),
      .s1_red       (s1_red_ff),
      .s1_green     (s1_green_ff),
      .s1_blue      (s1_blue_ff),
      .rsp_push     (rsp_push),
      .rsp_beat     (push_beat)
   );

   fgcb_rsp_buffer u_rsp_buffer (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_beat(push_beat),
      .pop_ready(rsp_ready),
      .out_valid(rsp_valid),
      .out_beat (out_beat),
      .level    (buf_level)
   );

   assign rsp_bin_number   = out_beat.bin_number;
   assign rsp_red_total    = out_beat.red;
   assign rsp_green_total  = out_beat.green;
   assign rsp_blue_total   = out_beat.blue;
   assign rsp_sample_total = out_beat.count;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(rsp_push && buf_level == 2'd2 && !pop))
      else $error("response buffer overrun");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      pending <= 3'd2)
      else $error("more responses outstanding than buffer entries");

   a_read_responds: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> rsp_valid)
      else $error("read result did not reach the response port");

   a_pixel_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_ctrl_ff.valid && s1_ctrl_ff.pixel) |-> !rsp_push)
      else $error("pixel beat produced a response");

endmodule

FILE: dv/frame_grid_color_binning_checker.sv
// Scoreboard for the frame grid color binning core: predicts each bin read and checks responses.
`timescale 1ns / 100ps
module frame_grid_color_binning_checker
   import fgcb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_operation,
   input  logic                   req_frame_start,
   input  logic [PIX_W-1:0]       req_blue,
   input  logic [PIX_W-1:0]       req_green,
   input  logic [PIX_W-1:0]       req_red,
   input  logic [BIN_NUM_W-1:0]   req_read_index,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [BIN_NUM_W-1:0]   rsp_bin_number,
   input  logic [TOTAL_W-1:0]     rsp_red_total,
   input  logic [TOTAL_W-1:0]     rsp_green_total,
   input  logic [TOTAL_W-1:0]     rsp_blue_total,
   input  logic [COUNT_W-1:0]     rsp_sample_total,
   output int unsigned            mismatch_count,
   output int unsigned            reads_checked,
   output int unsigned            reads_pending
);

   localparam int COLS    = 16;
   localparam int ROWS    = 9;
   localparam int BINS    = COLS * ROWS;
   localparam int DIM_MAX = 8192;

   logic [CFG_DIM_W-1:0]  width_reg;
   logic [CFG_DIM_W-1:0]  height_reg;
   logic [CFG_SKIP_W-1:0] skip_reg;

   logic [TOTAL_W-1:0] red_acc   [BINS];
   logic [TOTAL_W-1:0] green_acc [BINS];
   logic [TOTAL_W-1:0] blue_acc  [BINS];
   logic [COUNT_W-1:0] hit_count [BINS];
   logic               owner     [BINS];
   logic               cur_parity;

   logic [12:0] col_x, row_y, col_frac, row_frac;
   logic [3:0]  col_cell, row_cell;
   logic [7:0]  col_step, row_step;

   rsp_beat_type expected_bin_reads [$];
   int unsigned  errors;
   int unsigned  checked;

   function automatic logic [14:0] clamp_dim(logic [CFG_DIM_W-1:0] v, int unsigned lo);
      if (v < lo) return 15'(lo);
      if (v > DIM_MAX) return 15'(DIM_MAX);
      return 15'(v);
   endfunction

   function automatic logic [TOTAL_W-1:0] add_sat(logic [TOTAL_W-1:0] a, logic [PIX_W-1:0] b);
      logic [TOTAL_W:0] s;
      s = {1'b0, a} + (TOTAL_W + 1)'(b);
      return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
   endfunction

   function automatic logic [7:0] next_step(logic [7:0] p);
      return (p >= skip_reg) ? 8'd0 : p + 8'd1;
   endfunction

   function automatic void compare_field(string name, logic [TOTAL_W-1:0] want,
                                         logic [TOTAL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   task automatic clear_bin(int unsigned i);
      red_acc[i]   = '0;
      green_acc[i] = '0;
      blue_acc[i]  = '0;
      hit_count[i] = '0;
   endtask

   task automatic home_position();
      col_x = '0;
      row_y = '0;
      col_cell = '0;
      row_cell = '0;
      col_frac = '0;
      row_frac = '0;
      col_step = '0;
      row_step = '0;
   endtask

   task automatic restore_reset();
      width_reg  = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      skip_reg   = SAMPLE_SKIP_RESET;
      for (int i = 0; i < BINS; i++) begin
         clear_bin(i);
         owner[i] = 1'b0;
      end
      cur_parity = 1'b0;
      home_position();
      expected_bin_reads.delete();
   endtask

   task automatic apply_setting(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_FRAME_WIDTH: begin
            width_reg = data[CFG_DIM_W-1:0];
         end
         CSR_FRAME_HEIGHT: begin
            height_reg = data[CFG_DIM_W-1:0];
         end
         CSR_SAMPLE_SKIP: begin
            skip_reg = data[CFG_SKIP_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   // Flip the frame parity; bins still tagged with the new parity hold stale data.
   task automatic begin_frame();
      cur_parity = ~cur_parity;
      for (int i = 0; i < BINS; i++) begin
         if (owner[i] == cur_parity) begin
            clear_bin(i);
            owner[i] = ~cur_parity;
         end
      end
      home_position();
   endtask

   task automatic step_position();
      logic [14:0] w, h, frac;
      w = clamp_dim(width_reg, COLS);
      h = clamp_dim(height_reg, ROWS);
      if (15'(col_x) + 15'd1 < w) begin
         col_x = col_x + 13'd1;
         frac = 15'(col_frac) + 15'(COLS);
         if (frac >= w) begin
            frac = frac - w;
            if (col_cell < COLS - 1) col_cell = col_cell + 4'd1;
         end
         col_frac = frac[12:0];
         col_step = next_step(col_step);
      end else begin
         col_x = '0;
         col_cell = '0;
         col_frac = '0;
         col_step = '0;
         if (15'(row_y) + 15'd1 < h) begin
            row_y = row_y + 13'd1;
            frac = 15'(row_frac) + 15'(ROWS);
            if (frac >= h) begin
               frac = frac - h;
               if (row_cell < ROWS - 1) row_cell = row_cell + 4'd1;
            end
            row_frac = frac[12:0];
            row_step = next_step(row_step);
         end else begin
            row_y = '0;
            row_cell = '0;
            row_frac = '0;
            row_step = '0;
         end
      end
   endtask

   task automatic bin_pixel(logic fs, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                            logic [PIX_W-1:0] b);
      int unsigned idx;
      if (fs) begin_frame();
      // A shrunken skip leaves a phase past its end: wrap it to zero.
      if (col_step > skip_reg) col_step = '0;
      if (row_step > skip_reg) row_step = '0;
      if (col_step == 0 && row_step == 0) begin
         idx = ((row_cell < ROWS) ? int'(row_cell) : ROWS - 1) * COLS + int'(col_cell);
         if (owner[idx] != cur_parity) begin
            clear_bin(idx);
            owner[idx] = cur_parity;
         end
         red_acc[idx]   = add_sat(red_acc[idx], r);
         green_acc[idx] = add_sat(green_acc[idx], g);
         blue_acc[idx]  = add_sat(blue_acc[idx], b);
         if (hit_count[idx] != COUNT_MAX) hit_count[idx] = hit_count[idx] + COUNT_W'(1);
      end
      step_position();
   endtask

   task automatic queue_bin_read(logic [BIN_NUM_W-1:0] idx);
      rsp_beat_type beat;
      if (idx >= BINS) return;
      beat = '0;
      beat.bin_number = idx;
      if (owner[idx] == cur_parity) begin
         beat.red   = red_acc[idx];
         beat.green = green_acc[idx];
         beat.blue  = blue_acc[idx];
         beat.count = hit_count[idx];
      end
      expected_bin_reads.insert(expected_bin_reads.size(), beat);
   endtask

   task automatic check_result();
      rsp_beat_type want;
      if (expected_bin_reads.size() == 0) begin
         $error("unexpected result beat for bin %0d", rsp_bin_number);
         errors++;
         return;
      end
      want = expected_bin_reads.pop_front();
      checked++;
      compare_field("bin_number", TOTAL_W'(want.bin_number), TOTAL_W'(rsp_bin_number));
      compare_field("red_total", want.red, rsp_red_total);
      compare_field("green_total", want.green, rsp_green_total);
      compare_field("blue_total", want.blue, rsp_blue_total);
      compare_field("sample_total", TOTAL_W'(want.count), TOTAL_W'(rsp_sample_total));
   endtask

   initial begin
      errors = 0;
      checked = 0;
   end

   // Responses first: a read accepted at this edge answers only after stage 1 and the response buffer.
   always @(posedge clock) begin
      if (reset) begin
         restore_reset();
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (csr_write_enable) apply_setting(csr_index, csr_write_data);
         if (req_valid && req_ready) begin
            if (req_operation == OP_PIXEL) begin
               bin_pixel(req_frame_start, req_red, req_green, req_blue);
            end else begin
               queue_bin_read(req_read_index);
            end
         end
      end
      mismatch_count <= errors;
      reads_checked  <= checked;
      reads_pending  <= expected_bin_reads.size();
   end

endmodule

FILE: dv/frame_grid_color_binning_core_tb.sv
// Testbench top for the frame grid color binning core: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module frame_grid_color_binning_core_tb;
   import fgcb_pkg::*;

   localparam int QUIET_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_BEATS    = 1500;
   localparam int CALM_BEATS      = 240;
   localparam int PHASE_BEATS     = 120;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_operation;
   logic                   req_frame_start;
   logic [PIX_W-1:0]       req_blue;
   logic [PIX_W-1:0]       req_green;
   logic [PIX_W-1:0]       req_red;
   logic [BIN_NUM_W-1:0]   req_read_index;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [BIN_NUM_W-1:0]   rsp_bin_number;
   logic [TOTAL_W-1:0]     rsp_red_total;
   logic [TOTAL_W-1:0]     rsp_green_total;
   logic [TOTAL_W-1:0]     rsp_blue_total;
   logic [COUNT_W-1:0]     rsp_sample_total;

   int unsigned mismatch_count;
   int unsigned reads_checked;
   int unsigned reads_pending;

   int unsigned tx_idle_level;
   int unsigned rx_idle_level;
   bit          hold_off_req;
   int unsigned beats_sent;
   int unsigned settings_used;

   frame_grid_color_binning_core dut (.*);

   frame_grid_color_binning_checker bin_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: random short stalls, plus one long hold-off on request.
   initial begin : response_sink
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (rx_idle_level != 0 && $urandom_range(0, 9) < rx_idle_level) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
            quiet = 0;
         else
            quiet++;
      end
      $display("frame_grid_color_binning_core regression: fail");
      $finish;
   end

   // Hold valid and payload until the beat is taken.
   task automatic send_beat(logic op, logic fs, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] idx);
      @(negedge clock);
      if (tx_idle_level != 0 && $urandom_range(0, 9) < tx_idle_level) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_frame_start <= fs;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      req_read_index  <= idx;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic send_pixel(logic fs);
      send_beat(OP_PIXEL, fs, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_read(logic [7:0] idx);
      send_beat(OP_READ, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), idx);
   endtask

   // Drop valid, drain every pending read, then give trailing pixel writes time to land.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (reads_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_settings(logic [13:0] w, logic [13:0] h, logic [7:0] s);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FRAME_WIDTH;
      csr_write_data   <= w;
      @(negedge clock);
      csr_index        <= CSR_FRAME_HEIGHT;
      csr_write_data   <= h;
      @(negedge clock);
      csr_index        <= CSR_SAMPLE_SKIP;
      csr_write_data   <= {6'd0, s};
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic run_directed();
      // Reset geometry: only the origin lands in a bin.
      send_beat(OP_PIXEL, 1'b1, 8'd255, 8'd0, 8'd170, 8'hFF);
      send_beat(OP_PIXEL, 1'b0, 8'd0, 8'd255, 8'd85, 8'h00);
      send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      apply_settings(14'd16, 14'd9, 8'd0);
      send_beat(OP_PIXEL, 1'b1, 8'd0, 8'd255, 8'd85, 8'h55);
      send_beat(OP_PIXEL, 1'b0, 8'd255, 8'd255, 8'd255, 8'hAA);
      // Frame flag on a read must be ignored.
      send_beat(OP_READ, 1'b1, 8'd255, 8'd255, 8'd255, 8'd1);
      send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd143);
      send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd144);
      send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd255);
      send_beat(OP_PIXEL, 1'b1, 8'd1, 8'd2, 8'd3, 8'd0);
      send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd1);
      send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      // Two frames on, bin 1 carries the current parity from long ago: it must read empty.
      send_beat(OP_PIXEL, 1'b1, 8'd4, 8'd5, 8'd6, 8'd0);
      send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd1);
      send_beat(OP_READ, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
   endtask

   task automatic pick_settings(int unsigned phase, output logic [13:0] w,
                                output logic [13:0] h, output logic [7:0] s);
      case (phase)
         0: begin w = 14'd16;    h = 14'd9;     s = 8'd0;   end
         1: begin w = 14'd16383; h = 14'd16383; s = 8'd255; end
         2: begin w = 14'd8192;  h = 14'd9;     s = 8'd1;   end
         3: begin w = 14'd5;     h = 14'd3;     s = 8'd255; end
         4: begin w = 14'd17;    h = 14'd8192;  s = 8'd0;   end
         5: begin w = 14'd8193;  h = 14'd8191;  s = 8'd2;   end
         6: begin w = 14'd0;     h = 14'd0;     s = 8'd0;   end
         default: begin
            if ($urandom_range(0, 7) == 0) begin
               w = 14'($urandom);
               h = 14'($urandom);
               s = 8'($urandom);
            end else begin
               w = 14'($urandom_range(16, 40));
               h = 14'($urandom_range(9, 20));
               s = 8'($urandom_range(0, 3));
            end
         end
      endcase
   endtask

   // One frame: start flag, then pixels, with bin reads mixed in.
   task automatic send_frame();
      int unsigned len;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(140, 320) : $urandom_range(1, 180);
      send_pixel(1'b1);
      repeat (len) begin
         send_pixel(1'b0);
         if ($urandom_range(0, 3) == 0) send_read(8'($urandom_range(0, 143)));
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 12)) begin
         if ($urandom_range(0, 1) == 0) send_pixel(1'($urandom));
         else send_read(8'($urandom));
      end
   endtask

   task automatic run_random();
      int unsigned phase, first, target;
      logic [13:0] w, h;
      logic [7:0]  s;
      phase = 0;
      first = beats_sent;
      while (beats_sent - first < RANDOM_BEATS) begin
         pick_settings(phase, w, h, s);
         apply_settings(w, h, s);
         if (beats_sent - first + CALM_BEATS >= RANDOM_BEATS) begin
            tx_idle_level = 0;
            rx_idle_level = 0;
         end else begin
            tx_idle_level = $urandom_range(0, 3);
            rx_idle_level = $urandom_range(0, 3);
         end
         if (phase == 8) begin
            // Stall the response side long enough for the input to back up.
            hold_off_req = 1'b1;
            repeat (40) send_read(8'($urandom_range(0, 143)));
         end
         target = beats_sent + PHASE_BEATS;
         // Sometimes carry on mid-frame under the new settings.
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 60)) begin
               send_pixel(1'b0);
               if ($urandom_range(0, 2) == 0) send_read(8'($urandom_range(0, 143)));
            end
         end
         while (beats_sent < target) begin
            if ($urandom_range(0, 4) != 0) send_frame();
            else send_noise();
         end
         phase++;
      end
   endtask

   initial begin : stimulus
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_FRAME_WIDTH;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_operation    = OP_PIXEL;
      req_frame_start  = 1'b0;
      req_blue         = '0;
      req_green        = '0;
      req_red          = '0;
      req_read_index   = '0;
      tx_idle_level    = 0;
      rx_idle_level    = 0;
      hold_off_req     = 1'b0;
      beats_sent       = 0;
      settings_used    = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      settle();
      $display("Ran %0d request beats over %0d register settings; %0d bin reads compared.",
               beats_sent, settings_used, reads_checked);
      $display("Covered clamped and maximum frame sizes, skips 0 to 255 and a long output stall.");
      if (mismatch_count == 0) begin
         $display("frame_grid_color_binning_core regression: pass");
      end else begin
         $display("frame_grid_color_binning_core regression: fail");
      end
      $finish;
   end

endmodule
